[hw/rtl/pnh_pkg.sv]
// Package for the plain netpbm header parser: phase encoding, character
// codes, status and format codes and the result word layout.
// No dependencies.
`default_nettype none

package pnh_pkg;

  // Parser phase, one-hot
  typedef enum logic [6:0] {
    PH_SEARCH      = 7'b0000001,
    PH_AFTER_P     = 7'b0000010,
    PH_AFTER_DIGIT = 7'b0000100,
    PH_WIDTH       = 7'b0001000,
    PH_HEIGHT      = 7'b0010000,
    PH_MAXV        = 7'b0100000,
    PH_DONE        = 7'b1000000
  } phase_t;

  // Character codes
  localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
  localparam logic [7:0] CH_LF    = 8'h0A;  // newline
  localparam logic [7:0] CH_P     = 8'h50;  // 'P'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_ONE   = 8'h31;  // '1'
  localparam logic [7:0] CH_THREE = 8'h33;  // '3'
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_P      = 3'd1;
  localparam logic [2:0] ST_BAD_MAGIC = 3'd2;
  localparam logic [2:0] ST_TRUNCATED = 3'd3;
  localparam logic [2:0] ST_OVERFLOW  = 3'd4;

  // Format codes
  localparam logic [1:0] FMT_P1 = 2'd0;
  localparam logic [1:0] FMT_P2 = 2'd1;
  localparam logic [1:0] FMT_P3 = 2'd2;

  // Result word: status, format, width, height, max_value, padded to bytes
  localparam int unsigned OUT_TDATA_W = 56;

  typedef struct packed {
    logic [15:0] max_value;
    logic [15:0] height;
    logic [15:0] width;
    logic [1:0]  format;
    logic [2:0]  status;
  } result_t;

endpackage

`default_nettype wire

[hw/rtl/plain_netpbm_header_parser.sv]
// Plain netpbm (P1/P2/P3) header parser top level: input register, parse
// logic and result register. Depends on pnh_pkg.
`default_nettype none

//  channel | ports                          | contents
//  --------+--------------------------------+------------------------------------
//  input   | in_tvalid/in_tready/in_tdata   | tdata[7:0] byte_value
//          | in_tlast                       | end_of_file
//  result  | out_tvalid/out_tready/out_tdata| status, format, width, height, max
//
// One byte per cycle unless the input stage holds: a byte is registered,
// parsed against the state registers and any header result is registered
// for output. The input stage only holds when its byte produces a result
// while the result register is still full; bytes that produce nothing flow on.
// rst_n is synchronous, active low, and returns the parser to the search phase.
module plain_netpbm_header_parser #(
  parameter int unsigned NUMBER_BITS = 16
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  input  wire  [7:0]                        in_tdata,   // [7:0] byte_value
  input  wire                               in_tlast,   // end_of_file
  output logic                              out_tvalid,
  input  wire                               out_tready,
  // [2:0] status, [4:3] format, [20:5] width, [36:21] height,
  // [52:37] max_value, [55:53] zero
  output logic [pnh_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import pnh_pkg::*;

  localparam int unsigned MW = NUMBER_BITS + 4;
  localparam logic [NUMBER_BITS-1:0] NUM_LIMIT = {NUMBER_BITS{1'b1}};

  // Input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_eof_r;
  logic       s1_fire;

  // Parser state
  phase_t                 phase_r, phase_nxt;
  logic                   in_comment_r, in_comment_nxt;
  logic [1:0]             format_r, format_nxt;
  logic [NUMBER_BITS-1:0] acc_r, acc_nxt;
  logic                   in_digits_r, in_digits_nxt;
  logic [NUMBER_BITS-1:0] width_r, width_nxt;
  logic [NUMBER_BITS-1:0] height_r, height_nxt;

  // Result register
  logic    out_valid_r;
  result_t res_r, res_nxt;
  logic    emit;

  // Byte classification
  logic [7:0]    c;
  logic          is_digit, is_space, proc;
  logic [MW-1:0] prod;
  logic          ovf;

  assign c        = s1_byte_r;
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  assign proc     = (phase_r != PH_DONE) && (in_comment_r ? (c == CH_LF) : (c != CH_HASH));
  assign prod     = (MW'(acc_r) << 3) + (MW'(acc_r) << 1) + MW'(c - CH_ZERO);
  assign ovf      = |prod[MW-1:NUMBER_BITS];

  // Parse step, then end-of-file handling
  always_comb begin
    phase_nxt      = phase_r;
    in_comment_nxt = in_comment_r;
    format_nxt     = format_r;
    acc_nxt        = acc_r;
    in_digits_nxt  = in_digits_r;
    width_nxt      = width_r;
    height_nxt     = height_r;
    emit           = 1'b0;
    res_nxt        = '0;

    // comment tracking
    if (phase_r != PH_DONE) begin
      if (in_comment_r && (c == CH_LF)) begin
        in_comment_nxt = 1'b0;
      end else if (!in_comment_r && (c == CH_HASH)) begin
        in_comment_nxt = 1'b1;
      end
    end

    if (proc) begin
      case (phase_r)
        PH_SEARCH: begin
          if (c == CH_P) phase_nxt = PH_AFTER_P;
        end
        PH_AFTER_P: begin
          if ((c >= CH_ONE) && (c <= CH_THREE)) begin
            format_nxt = 2'(c - CH_ONE);
            phase_nxt  = PH_AFTER_DIGIT;
          end else begin
            emit           = 1'b1;
            res_nxt.status = ST_BAD_MAGIC;
          end
        end
        PH_AFTER_DIGIT: begin
          if (is_space) begin
            phase_nxt = PH_WIDTH;
          end else begin
            emit           = 1'b1;
            res_nxt.status = ST_BAD_MAGIC;
          end
        end
        PH_WIDTH, PH_HEIGHT, PH_MAXV: begin
          if (is_digit) begin
            in_digits_nxt = 1'b1;
            if (ovf) begin
              emit           = 1'b1;
              res_nxt.status = ST_OVERFLOW;
              if (phase_r == PH_WIDTH) begin
                res_nxt.width = 16'(NUM_LIMIT);
              end else if (phase_r == PH_HEIGHT) begin
                res_nxt.width  = 16'(width_r);
                res_nxt.height = 16'(NUM_LIMIT);
              end else begin
                res_nxt.width     = 16'(width_r);
                res_nxt.height    = 16'(height_r);
                res_nxt.max_value = 16'(NUM_LIMIT);
              end
            end else begin
              acc_nxt = prod[NUMBER_BITS-1:0];
            end
          end else if (in_digits_r) begin
            in_digits_nxt = 1'b0;
            if (phase_r == PH_WIDTH) begin
              width_nxt = acc_r;
              acc_nxt   = '0;
              phase_nxt = PH_HEIGHT;
            end else if (phase_r == PH_HEIGHT) begin
              height_nxt = acc_r;
              acc_nxt    = '0;
              if (format_r == FMT_P1) begin
                emit              = 1'b1;
                res_nxt.status    = ST_OK;
                res_nxt.width     = 16'(width_r);
                res_nxt.height    = 16'(acc_r);
                res_nxt.max_value = 16'd1;
              end else begin
                phase_nxt = PH_MAXV;
              end
            end else begin
              emit              = 1'b1;
              res_nxt.status    = ST_OK;
              res_nxt.width     = 16'(width_r);
              res_nxt.height    = 16'(height_r);
              res_nxt.max_value = 16'(acc_r);
            end
          end
        end
        default: ;
      endcase
    end

    if (emit) begin
      phase_nxt      = PH_DONE;
      res_nxt.format = format_nxt;
    end

    // end of file closes any open header, then clears the parser
    if (s1_eof_r) begin
      if (!emit && (phase_nxt != PH_DONE)) begin
        emit           = 1'b1;
        res_nxt.format = format_nxt;
        if ((phase_nxt == PH_MAXV) && in_digits_nxt) begin
          res_nxt.status    = ST_OK;
          res_nxt.width     = 16'(width_nxt);
          res_nxt.height    = 16'(height_nxt);
          res_nxt.max_value = 16'(acc_nxt);
        end else if (phase_nxt == PH_SEARCH) begin
          res_nxt.status = ST_NO_P;
          res_nxt.format = FMT_P1;
        end else begin
          res_nxt.status = ST_TRUNCATED;
          res_nxt.width  = 16'(width_nxt);
          res_nxt.height = 16'(height_nxt);
        end
      end
      phase_nxt      = PH_SEARCH;
      in_comment_nxt = 1'b0;
      format_nxt     = FMT_P1;
      acc_nxt        = '0;
      in_digits_nxt  = 1'b0;
      width_nxt      = '0;
      height_nxt     = '0;
    end
  end

  // Handshake: the input stage holds only when its result cannot be stored
  assign s1_fire   = s1_valid_r && (!emit || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_eof_r  <= in_tlast;
    end
  end

  // Parser state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_SEARCH;
      in_comment_r <= 1'b0;
      format_r     <= FMT_P1;
      acc_r        <= '0;
      in_digits_r  <= 1'b0;
      width_r      <= '0;
      height_r     <= '0;
    end else if (s1_fire) begin
      phase_r      <= phase_nxt;
      in_comment_r <= in_comment_nxt;
      format_r     <= format_nxt;
      acc_r        <= acc_nxt;
      in_digits_r  <= in_digits_nxt;
      width_r      <= width_nxt;
      height_r     <= height_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(res_r);

endmodule

`default_nettype wire

[hw/rtl/pnh_checker.sv]
// Port-level checks for the plain netpbm header parser, bound to the top level.
// Depends on pnh_pkg and plain_netpbm_header_parser.
`default_nettype none

module pnh_checker (
  input wire                             clk,
  input wire                             rst_n,
  input wire                             out_tvalid,
  input wire                             out_tready,
  input wire [pnh_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import pnh_pkg::*;

  // A stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Status and format stay within their codes
  a_codes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[2:0] <= ST_OVERFLOW) && (out_tdata[4:3] <= FMT_P3))
    else $error("status or format code out of range");

  // A good bitmap header always reports a maximum of one
  a_p1_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2:0] == ST_OK) && (out_tdata[4:3] == FMT_P1)
    |-> out_tdata[52:37] == 16'd1)
    else $error("bitmap header without maximum of one");

  // Missing magic and bad magic carry no dimensions
  a_no_dims: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ((out_tdata[2:0] == ST_NO_P) || (out_tdata[2:0] == ST_BAD_MAGIC))
    |-> out_tdata[52:5] == '0)
    else $error("dimensions reported without a valid magic");

  // Padding bits stay zero
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_TDATA_W-1:53] == '0)
    else $error("result padding not zero");

endmodule

bind plain_netpbm_header_parser pnh_checker u_pnh_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

[tb/sv/pnh_header_checker.sv]
// Header checker for the plain netpbm header parser: follows the byte stream,
// predicts each header result and compares it with the result channel.
// Depends on pnh_pkg.
module pnh_header_checker #(
  parameter int unsigned NUMBER_BITS = 16
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  input  wire                              in_tready,
  input  wire [7:0]                        in_tdata,   // [7:0] byte_value
  input  wire                              in_tlast,   // end_of_file
  input  wire                              out_tvalid,
  input  wire                              out_tready,
  // [2:0] status, [4:3] format, [20:5] width, [36:21] height, [52:37] max_value
  input  wire [pnh_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output int unsigned                      fail_count,
  output int unsigned                      headers_pending
);
  import pnh_pkg::*;

  localparam longint unsigned NUM_MAX = (64'd1 << NUMBER_BITS) - 64'd1;

  // Parser state as seen from the byte stream
  phase_t          phase;
  logic            in_comment;
  logic [1:0]      fmt_code;
  longint unsigned acc;
  logic            in_digits;
  longint unsigned width_acc;
  longint unsigned height_acc;

  result_t pending_headers[$];

  function automatic void restart_parser();
    phase      = PH_SEARCH;
    in_comment = 1'b0;
    fmt_code   = FMT_P1;
    acc        = 0;
    in_digits  = 1'b0;
    width_acc  = 0;
    height_acc = 0;
  endfunction

  function automatic result_t header(input logic [2:0] st, input longint unsigned w,
                                     input longint unsigned h, input longint unsigned mx);
    result_t r;
    r.status    = st;
    r.format    = fmt_code;
    r.width     = w[15:0];
    r.height    = h[15:0];
    r.max_value = mx[15:0];
    return r;
  endfunction

  // One byte after comment removal; returns 1 when it completes a header
  function automatic bit parse_char(input logic [7:0] c, output result_t r);
    bit              dig;
    bit              done;
    longint unsigned nv;
    dig  = (c >= CH_ZERO) && (c <= CH_NINE);
    done = 1'b0;
    r    = '0;
    case (phase)
      PH_SEARCH: begin
        if (c == CH_P) phase = PH_AFTER_P;
      end
      PH_AFTER_P: begin
        if (c >= CH_ONE && c <= CH_THREE) begin
          fmt_code = 2'(c - CH_ONE);
          phase    = PH_AFTER_DIGIT;
        end else begin
          r    = header(ST_BAD_MAGIC, 0, 0, 0);
          done = 1'b1;
        end
      end
      PH_AFTER_DIGIT: begin
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
          phase = PH_WIDTH;
        end else begin
          r    = header(ST_BAD_MAGIC, 0, 0, 0);
          done = 1'b1;
        end
      end
      PH_WIDTH, PH_HEIGHT, PH_MAXV: begin
        if (dig) begin
          nv        = acc * 10 + longint'(c - CH_ZERO);
          in_digits = 1'b1;
          if (nv > NUM_MAX) begin
            // saturate the number being read and stop
            if (phase == PH_WIDTH)       r = header(ST_OVERFLOW, NUM_MAX, 0, 0);
            else if (phase == PH_HEIGHT) r = header(ST_OVERFLOW, width_acc, NUM_MAX, 0);
            else                         r = header(ST_OVERFLOW, width_acc, height_acc, NUM_MAX);
            done = 1'b1;
          end else begin
            acc = nv;
          end
        end else if (in_digits) begin
          in_digits = 1'b0;
          if (phase == PH_WIDTH) begin
            width_acc = acc;
            acc       = 0;
            phase     = PH_HEIGHT;
          end else if (phase == PH_HEIGHT) begin
            height_acc = acc;
            acc        = 0;
            if (fmt_code == FMT_P1) begin
              r    = header(ST_OK, width_acc, height_acc, 1);
              done = 1'b1;
            end else begin
              phase = PH_MAXV;
            end
          end else begin
            r    = header(ST_OK, width_acc, height_acc, acc);
            done = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (done) phase = PH_DONE;
    return done;
  endfunction

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Prediction on each input transaction, comparison on each result transaction
  always @(posedge clk) begin : track
    bit      produced;
    result_t hdr;
    result_t want;
    result_t seen;
    if (!rst_n) begin
      restart_parser();
      pending_headers.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        produced = 1'b0;
        if (phase != PH_DONE) begin
          if (in_comment) begin
            // the newline closing a comment is still parsed
            if (in_tdata == CH_LF) begin
              in_comment = 1'b0;
              produced   = parse_char(in_tdata, hdr);
            end
          end else if (in_tdata == CH_HASH) begin
            in_comment = 1'b1;
          end else begin
            produced = parse_char(in_tdata, hdr);
          end
        end
        if (in_tlast) begin
          if (!produced && phase != PH_DONE) begin
            if (phase == PH_MAXV && in_digits)
              hdr = header(ST_OK, width_acc, height_acc, acc);
            else if (phase == PH_SEARCH)
              hdr = header(ST_NO_P, 0, 0, 0);
            else
              hdr = header(ST_TRUNCATED, width_acc, height_acc, 0);
            produced = 1'b1;
          end
          restart_parser();
        end
        if (produced) pending_headers.push_back(hdr);
      end
      if (out_tvalid && out_tready) begin
        seen = out_tdata[$bits(result_t)-1:0];
        if (pending_headers.size() == 0) begin
          $error("header result with none predicted: status %0d format %0d",
                 seen.status, seen.format);
          fail_count++;
        end else begin
          want = pending_headers.pop_front();
          check_field("status", want.status, seen.status);
          check_field("format", want.format, seen.format);
          check_field("width", want.width, seen.width);
          check_field("height", want.height, seen.height);
          check_field("max_value", want.max_value, seen.max_value);
        end
      end
    end
    headers_pending = unsigned'(pending_headers.size());
  end

endmodule

[tb/sv/testbench.sv]
// Top of the header parser testbench: clock, reset, byte-stream files and
// receiver back-pressure; verdict from the header checker's counts.
// Depends on pnh_pkg, plain_netpbm_header_parser and pnh_header_checker.
module testbench;
  import pnh_pkg::*;

  localparam int unsigned NUMBER_BITS  = 16;
  localparam int unsigned RANDOM_BYTES = 1450;
  localparam int unsigned LONG_HOLD    = 400;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic [7:0]             in_tdata   = '0;    // [7:0] byte_value
  logic                   in_tlast   = 1'b0;  // end_of_file
  logic                   out_tready = 1'b0;
  wire                    in_tready;
  wire                    out_tvalid;
  wire [OUT_TDATA_W-1:0]  out_tdata;          // status, format, width, height, max_value

  int unsigned fail_count;
  int unsigned headers_pending;

  int unsigned tx_idle_pct = 16;
  int unsigned rx_idle_pct = 74;
  bit          hold_req    = 1'b0;
  int unsigned bytes_sent  = 0;

  logic [7:0] file_q[$];

  plain_netpbm_header_parser #(.NUMBER_BITS(NUMBER_BITS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  pnh_header_checker #(.NUMBER_BITS(NUMBER_BITS)) hdr_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tlast        (in_tlast),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .fail_count      (fail_count),
    .headers_pending (headers_pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop in case the stream locks up
  initial begin
    #200000;
    $display("plain_netpbm_header_parser: mismatch");
    $finish;
  end

  // Receiver: random ready, plus one long hold-off when asked for
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
        @(posedge clk);
      end
    end
  end

  // One byte transaction, with random idle cycles in front of it
  task automatic send_byte(input logic [7:0] b, input bit last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_file();
    if (file_q.size() == 0) file_q.push_back(8'($urandom_range(0, 255)));
    for (int i = 0; i < file_q.size(); i++) send_byte(file_q[i], i == file_q.size() - 1);
    bytes_sent += file_q.size();
    file_q.delete();
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) file_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] pick_space();
    return ($urandom_range(0, 5) == 5) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR));
  endfunction

  // Whitespace, a comment up to a newline, or one stray non-digit
  task automatic add_separator();
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0: repeat ($urandom_range(1, 4)) file_q.push_back(pick_space());
      1: begin
        file_q.push_back(CH_HASH);
        repeat ($urandom_range(0, 4)) begin
          do c = 8'($urandom_range(0, 255)); while (c == CH_LF);
          file_q.push_back(c);
        end
        file_q.push_back(CH_LF);
      end
      2: begin
        do c = 8'($urandom_range(0, 255));
        while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_HASH || c == CH_P);
        file_q.push_back(c);
      end
      default: file_q.push_back(CH_SPACE);
    endcase
  endtask

  initial begin
    logic [7:0]      magic;
    longint unsigned v;
    int unsigned     nums;
    int unsigned     cut;
    bit              pressure_done;
    pressure_done = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed files: no P, both bad magic cases, comment hiding a P with
    // bytes after the result, max value ended by end of file, overflow,
    // truncation
    add_text("Q");                   send_file();
    add_text("P4");                  send_file();
    add_text("P3x");                 send_file();
    add_text("#P\nP1 0 9 ");
    file_q.push_back(8'hFF);         send_file();
    add_text("P2\t65535 1 7");       send_file();
    add_text("P3 70000");            send_file();
    add_text("P2 5");                send_file();

    // Random files, mostly shaped like headers
    while (bytes_sent < RANDOM_BYTES) begin
      if (bytes_sent >= 2 * RANDOM_BYTES / 3) begin
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
      end else if (bytes_sent >= RANDOM_BYTES / 3) begin
        tx_idle_pct <= 74;
        rx_idle_pct <= 16;
      end

      // burst of short results while the receiver holds off
      if (!pressure_done && bytes_sent >= 200) begin
        pressure_done = 1'b1;
        hold_req <= 1'b1;
        repeat (8) begin
          add_text("P0");
          send_file();
        end
      end

      if ($urandom_range(99) < 80) begin
        repeat ($urandom_range(0, 2)) add_separator();
        file_q.push_back(CH_P);
        magic = ($urandom_range(99) < 6) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(CH_ONE, CH_THREE));
        file_q.push_back(magic);
        file_q.push_back(($urandom_range(99) < 6) ? 8'($urandom_range(0, 255)) : pick_space());
        nums = (magic == CH_ONE) ? 2 : 3;
        for (int i = 0; i < nums; i++) begin
          if (i > 0 || $urandom_range(0, 3) == 0) add_separator();
          case ($urandom_range(0, 19))
            0:       v = 65535;
            1:       v = $urandom_range(65536, 999999);
            2, 3:    v = $urandom_range(0, 65535);
            default: v = $urandom_range(0, 999);
          endcase
          if ($urandom_range(0, 9) == 0) add_text("0");
          add_text($sformatf("%0d", v));
        end
        if ($urandom_range(0, 3) != 0) add_separator();
        // broken file: cut short anywhere
        if ($urandom_range(99) < 12) begin
          cut = $urandom_range(1, file_q.size());
          file_q = file_q[0:cut-1];
        end
        repeat ($urandom_range(0, 2)) file_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 10)) file_q.push_back(8'($urandom_range(0, 255)));
      end
      send_file();
    end
    in_tvalid <= 1'b0;

    // Drain the remaining headers, then allow for the pipeline
    do @(posedge clk); while (headers_pending != 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && headers_pending == 0) begin
      $display("plain_netpbm_header_parser: match");
    end else begin
      $display("plain_netpbm_header_parser: mismatch");
    end
    $finish;
  end

endmodule
